### hw/rtl/dasd_pkg.sv
// Shared types and constants for the dual-axis settle detector.
`timescale 1ns / 1ps
`default_nettype none
package dasd_pkg;

   // Position and limit widths
   localparam int POS_BITS      = 16;
   localparam int LIM_BITS      = POS_BITS + 1;
   localparam int DIST_BITS     = 16;
   localparam int TOL_BITS      = 16;
   localparam int RUN_BITS      = 8;
   localparam int TIME_BITS     = 16;
   localparam int CSR_DATA_BITS = (LIM_BITS > TOL_BITS) ? LIM_BITS : TOL_BITS;
   localparam int CSR_IDX_BITS  = 3;

   localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};
   localparam logic [RUN_BITS-1:0]  RUN_MAX  = {RUN_BITS{1'b1}};

   // Reset values of the control registers
   localparam logic [POS_BITS-1:0]  TARGET_RESET  = '0;
   localparam logic [LIM_BITS-1:0]  WRAP_RESET    = LIM_BITS'(4096);
   localparam logic [TOL_BITS-1:0]  TOL_RESET     = TOL_BITS'(5);
   localparam logic [RUN_BITS-1:0]  SETTLE_RESET  = RUN_BITS'(10);
   localparam logic [TIME_BITS-1:0] TIMEOUT_RESET = TIME_BITS'(2000);

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_TARGET_Y     = 3'd0,
      CSR_TARGET_XI    = 3'd1,
      CSR_WRAP_LIMIT   = 3'd2,
      CSR_TOLERANCE    = 3'd3,
      CSR_SETTLE_COUNT = 3'd4,
      CSR_TIMEOUT_MS   = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_WAIT    = 2'd0,
      ST_SETTLED = 2'd1,
      ST_TIMEOUT = 2'd2
   } status_type;

   typedef struct packed {
      logic [POS_BITS-1:0]  pos_y;
      logic [POS_BITS-1:0]  pos_xi;
      logic [TIME_BITS-1:0] elapsed_ms;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [RUN_BITS-1:0]  run_length;
      logic [DIST_BITS-1:0] dist_y;
      logic [DIST_BITS-1:0] dist_xi;
   } rsp_type;

endpackage
`default_nettype wire

### hw/rtl/dual_axis_settle_detector.sv
// Top level of the dual-axis settle detector.
// Pipeline: a request is captured in the request register and its response in the
//    response register, which then drives the response handshake.
// Throughput: one request per cycle; the response register and the request
//    register advance together, so rsp_ready stalls ripple back to req_ready.
// Reset: synchronous, active high; clears both valid flags and the run counter
//    and loads the control registers with their defaults.
`timescale 1ns / 1ps
`default_nettype none
module dual_axis_settle_detector
   import dasd_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire req_type                  req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output rsp_type                       rsp_data,
   input  wire logic                     csr_wr_en,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   // Control registers
   logic [POS_BITS-1:0]  target_y_ff;
   logic [POS_BITS-1:0]  target_xi_ff;
   logic [LIM_BITS-1:0]  wrap_limit_ff;
   logic [TOL_BITS-1:0]  tolerance_ff;
   logic [RUN_BITS-1:0]  settle_count_ff;
   logic [TIME_BITS-1:0] timeout_ms_ff;

   // Pipeline registers
   logic                 req_valid_ff;
   req_type              req_data_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;
   logic [RUN_BITS-1:0]  run_ff;
   logic [RUN_BITS-1:0]  run_in;
   rsp_type              rsp_data_in;

   logic                 out_open;
   logic                 advance;
   logic [DIST_BITS-1:0] dist_y;
   logic [DIST_BITS-1:0] dist_xi;
   logic                 in_position;
   logic [RUN_BITS-1:0]  run_count;
   status_type           status;

   // Write control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         target_y_ff     <= TARGET_RESET;
         target_xi_ff    <= TARGET_RESET;
         wrap_limit_ff   <= WRAP_RESET;
         tolerance_ff    <= TOL_RESET;
         settle_count_ff <= SETTLE_RESET;
         timeout_ms_ff   <= TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TARGET_Y:     target_y_ff     <= csr_wdata[POS_BITS-1:0];
            CSR_TARGET_XI:    target_xi_ff    <= csr_wdata[POS_BITS-1:0];
            CSR_WRAP_LIMIT:   wrap_limit_ff   <= csr_wdata[LIM_BITS-1:0];
            CSR_TOLERANCE:    tolerance_ff    <= csr_wdata[TOL_BITS-1:0];
            CSR_SETTLE_COUNT: settle_count_ff <= csr_wdata[RUN_BITS-1:0];
            CSR_TIMEOUT_MS:   timeout_ms_ff   <= csr_wdata[TIME_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Handshake: move the request stage whenever the response register frees up
   assign out_open  = !rsp_valid_ff || rsp_ready;
   assign advance   = req_valid_ff && out_open;
   assign req_ready = !req_valid_ff || out_open;

   // Distances of both axes
   dasd_wrap_dist u_dist_y (
      .pos        (req_data_ff.pos_y),
      .target     (target_y_ff),
      .wrap_limit (wrap_limit_ff),
      .distance   (dist_y)
   );

   dasd_wrap_dist u_dist_xi (
      .pos        (req_data_ff.pos_xi),
      .target     (target_xi_ff),
      .wrap_limit (wrap_limit_ff),
      .distance   (dist_xi)
   );

   // Count the in-position run and decide the status
   always_comb begin
      in_position = (TOL_BITS'(dist_y) < tolerance_ff) &&
                    (TOL_BITS'(dist_xi) < tolerance_ff);
      if (!in_position) begin
         run_count = '0;
      end else if (run_ff == RUN_MAX) begin
         run_count = RUN_MAX;
      end else begin
         run_count = run_ff + RUN_BITS'(1);
      end

      if (req_data_ff.elapsed_ms >= timeout_ms_ff) begin
         status = ST_TIMEOUT;
      end else if (run_count >= settle_count_ff) begin
         status = ST_SETTLED;
      end else begin
         status = ST_WAIT;
      end

      // Clear the run after a final status
      run_in = (status == ST_WAIT) ? run_count : '0;

      rsp_data_in.status     = status;
      rsp_data_in.run_length = run_count;
      rsp_data_in.dist_y     = dist_y;
      rsp_data_in.dist_xi    = dist_xi;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         run_ff       <= '0;
      end else begin
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         if (out_open) begin
            rsp_valid_ff <= req_valid_ff;
         end
         if (advance) begin
            run_ff <= run_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

### hw/rtl/dasd_wrap_dist.sv
// Cyclic distance of one axis position from its target within one turn.
`timescale 1ns / 1ps
`default_nettype none
module dasd_wrap_dist
   import dasd_pkg::*;
(
   input  wire logic [POS_BITS-1:0]  pos,
   input  wire logic [POS_BITS-1:0]  target,
   input  wire logic [LIM_BITS-1:0]  wrap_limit,
   output logic      [DIST_BITS-1:0] distance
);

   localparam int WIDE_BITS = LIM_BITS + DIST_BITS;

   logic [POS_BITS-1:0]  gap;
   logic [LIM_BITS-1:0]  gap_ext;
   logic [LIM_BITS-1:0]  half_limit;
   logic [LIM_BITS-1:0]  raw_dist;
   logic [WIDE_BITS-1:0] raw_wide;

   // Direct gap between position and target
   assign gap        = (pos < target) ? (target - pos) : (pos - target);
   assign gap_ext    = LIM_BITS'(gap);
   assign half_limit = wrap_limit >> 1;

   // Pick the direct gap, the way around the wrap, or all ones past the wrap limit
   always_comb begin
      if (gap_ext < half_limit) begin
         raw_dist = gap_ext;
      end else if (gap_ext > wrap_limit) begin
         raw_dist = LIM_BITS'({WIDE_BITS{1'b1}});
      end else begin
         raw_dist = wrap_limit - gap_ext;
      end
   end

   // Saturate to the distance width
   always_comb begin
      raw_wide = WIDE_BITS'(raw_dist);
      if (gap_ext >= half_limit && gap_ext > wrap_limit) begin
         distance = DIST_MAX;
      end else if (raw_wide > WIDE_BITS'(DIST_MAX)) begin
         distance = DIST_MAX;
      end else begin
         distance = raw_wide[DIST_BITS-1:0];
      end
   end

endmodule
`default_nettype wire

### hw/rtl/dasd_checker.sv
// Port-level checks for the dual-axis settle detector, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module dasd_checker
   import dasd_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed or dropped");

   // Drop all responses out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A fresh response comes from an earlier accepted request
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without a matching request");

   // A saturated run always reaches the settle count
   a_full_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_WAIT |-> rsp_data.run_length != RUN_MAX)
      else $error("waiting reported with a full run");

endmodule

bind dual_axis_settle_detector dasd_checker u_dasd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire

### tb/dual_axis_settle_detector_test.sv
// Self-checking testbench for the dual-axis settle detector.
`timescale 1ns / 1ps
module dual_axis_settle_detector_test;
   import dasd_pkg::*;

   // Register indexes past the end of the map; writes there must be ignored
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNMAPPED_HI = 3'd7;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int RANDOM_PHASES   = 8;

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   req_type                  req_data  = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // Shadow copy of the control registers and the in-position run
   logic [POS_BITS-1:0]  cfg_target_y     = TARGET_RESET;
   logic [POS_BITS-1:0]  cfg_target_xi    = TARGET_RESET;
   logic [LIM_BITS-1:0]  cfg_wrap_limit   = WRAP_RESET;
   logic [TOL_BITS-1:0]  cfg_tolerance    = TOL_RESET;
   logic [RUN_BITS-1:0]  cfg_settle_count = SETTLE_RESET;
   logic [TIME_BITS-1:0] cfg_timeout_ms   = TIMEOUT_RESET;
   logic [RUN_BITS-1:0]  settle_run       = '0;

   req_type pending_samples[$];
   rsp_type predicted_reports[$];
   int      queued_samples = 0;
   int      fail_count     = 0;
   int      gap_pct        = 0;
   int      stall_pct      = 0;

   dual_axis_settle_detector DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Shortest distance around one turn, saturated to the distance width
   function automatic logic [DIST_BITS-1:0] cyclic_dist(input logic [POS_BITS-1:0] pos,
                                                        input logic [POS_BITS-1:0] target,
                                                        input logic [LIM_BITS-1:0] lim);
      logic [LIM_BITS-1:0] gap;
      logic [LIM_BITS-1:0] around;
      gap = LIM_BITS'((pos < target) ? target - pos : pos - target);
      if (gap < (lim >> 1))
         return gap[DIST_BITS-1:0];
      if (gap > lim)
         return DIST_MAX;
      around = lim - gap;
      return (around > LIM_BITS'(DIST_MAX)) ? DIST_MAX : around[DIST_BITS-1:0];
   endfunction

   // Advance the run for one sample and form its status report
   function automatic rsp_type predict_sample(input req_type sample);
      rsp_type r;
      r.dist_y  = cyclic_dist(sample.pos_y, cfg_target_y, cfg_wrap_limit);
      r.dist_xi = cyclic_dist(sample.pos_xi, cfg_target_xi, cfg_wrap_limit);
      if (r.dist_y < cfg_tolerance && r.dist_xi < cfg_tolerance) begin
         if (settle_run != RUN_MAX)
            settle_run = settle_run + RUN_BITS'(1);
      end else begin
         settle_run = '0;
      end
      r.run_length = settle_run;
      if (sample.elapsed_ms >= cfg_timeout_ms)
         r.status = ST_TIMEOUT;
      else if (settle_run >= cfg_settle_count)
         r.status = ST_SETTLED;
      else
         r.status = ST_WAIT;
      // a final status restarts the run
      if (r.status != ST_WAIT)
         settle_run = '0;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // Driver: present queued requests, predict each one as it is accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            predicted_reports.push_back(predict_sample(req_data));
         if (!req_valid || req_ready) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= gap_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_samples.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each accepted response against the oldest prediction
   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_reports.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               want = predicted_reports.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_data.status));
               check_field("run_length", 32'(want.run_length), 32'(rsp_data.run_length));
               check_field("dist_y", 32'(want.dist_y), 32'(rsp_data.dist_y));
               check_field("dist_xi", 32'(want.dist_xi), 32'(rsp_data.dist_xi));
            end
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx, input int unsigned value);
      logic [CSR_DATA_BITS-1:0] word;
      word = CSR_DATA_BITS'(value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= word;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (csr_index_type'(idx))
         CSR_TARGET_Y:     cfg_target_y     = word[POS_BITS-1:0];
         CSR_TARGET_XI:    cfg_target_xi    = word[POS_BITS-1:0];
         CSR_WRAP_LIMIT:   cfg_wrap_limit   = word[LIM_BITS-1:0];
         CSR_TOLERANCE:    cfg_tolerance    = word[TOL_BITS-1:0];
         CSR_SETTLE_COUNT: cfg_settle_count = word[RUN_BITS-1:0];
         CSR_TIMEOUT_MS:   cfg_timeout_ms   = word[TIME_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic push_sample(input int unsigned py, input int unsigned px,
                              input int unsigned el);
      req_type s;
      s.pos_y      = POS_BITS'(py);
      s.pos_xi     = POS_BITS'(px);
      s.elapsed_ms = TIME_BITS'(el);
      pending_samples.push_back(s);
      queued_samples++;
   endtask

   // Hold the sender until every request has come back, then let the block settle
   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_samples.size() != 0 || req_valid || predicted_reports.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // Position within +/- span of a target, folded back into one turn
   function automatic int unsigned near_target(input logic [POS_BITS-1:0] target,
                                               input int span);
      longint p;
      longint lim;
      lim = (cfg_wrap_limit == 0) ? longint'(65536) : longint'(cfg_wrap_limit);
      p = longint'(target) + longint'($urandom_range(2 * span)) - longint'(span);
      if (p < 0)
         p += lim;
      if (p >= lim)
         p -= lim;
      return int'(p[POS_BITS-1:0]);
   endfunction

   // One move: elapsed time climbs while the axes mostly hover at their targets
   task automatic queue_move();
      int len;
      int span;
      int el;
      len  = $urandom_range(4, 40);
      span = (cfg_tolerance < 1000) ? int'(cfg_tolerance) + 1 : 1000;
      el   = $urandom_range(0, 5);
      for (int i = 0; i < len; i++) begin
         el += $urandom_range(0, 12);
         if (el > 65535)
            el = 65535;
         if ($urandom_range(99) < 75)
            push_sample(near_target(cfg_target_y, span), near_target(cfg_target_xi, span), el);
         else
            push_sample($urandom, $urandom, el);
      end
   endtask

   task automatic random_setup();
      int unsigned lim;
      case ($urandom_range(5))
         0: lim = 1;
         1: lim = 2;
         2: lim = 4096;
         3: lim = 65536;
         4: lim = 131071;
         default: lim = $urandom_range(3, 65536);
      endcase
      write_reg(CSR_WRAP_LIMIT, lim);
      write_reg(CSR_TARGET_Y, (lim > 65536) ? $urandom_range(65535) : $urandom_range(lim - 1));
      write_reg(CSR_TARGET_XI, (lim > 65536) ? $urandom_range(65535) : $urandom_range(lim - 1));
      write_reg(CSR_TOLERANCE,
                ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(1, 40));
      case ($urandom_range(3))
         0: write_reg(CSR_SETTLE_COUNT, 1);
         1: write_reg(CSR_SETTLE_COUNT, 255);
         default: write_reg(CSR_SETTLE_COUNT, $urandom_range(2, 15));
      endcase
      case ($urandom_range(7))
         0: write_reg(CSR_TIMEOUT_MS, 0);
         1: write_reg(CSR_TIMEOUT_MS, 65535);
         default: write_reg(CSR_TIMEOUT_MS, $urandom_range(20, 400));
      endcase
   endtask

   initial begin
      int stop_at;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Defaults: in position on both sides of the wrap, settle, time out
      push_sample(0, 0, 0);
      push_sample(4095, 1, 10);
      for (int i = 0; i < 8; i++)
         push_sample(i % 5, 4096 - (i % 5), 20 + i);
      push_sample(2048, 2047, 100);
      push_sample(65535, 65535, 65535);
      push_sample(3, 3, 1999);
      push_sample(3, 3, 2000);
      push_sample(5, 0, 0);
      push_sample(4101, 4096, 0);
      wait_drained();

      // Zero wrap limit and zero settle count; unmapped writes change nothing
      write_reg(CSR_WRAP_LIMIT, 0);
      write_reg(CSR_SETTLE_COUNT, 0);
      write_reg(CSR_TOLERANCE, 65535);
      write_reg(CSR_TIMEOUT_MS, 65535);
      write_reg(CSR_TARGET_Y, 65535);
      write_reg(CSR_TARGET_XI, 0);
      write_reg(CSR_UNMAPPED_LO, 'h1FFFF);
      write_reg(CSR_UNMAPPED_HI, 'h1FFFF);
      push_sample(65535, 0, 65534);
      push_sample(0, 1, 0);
      push_sample(65535, 0, 65535);
      wait_drained();

      // Zero timeout, widest wrap limit, zero tolerance
      write_reg(CSR_TIMEOUT_MS, 0);
      write_reg(CSR_WRAP_LIMIT, 'h1FFFF);
      write_reg(CSR_TOLERANCE, 0);
      write_reg(CSR_SETTLE_COUNT, 255);
      write_reg(CSR_TARGET_Y, 0);
      push_sample(0, 0, 0);
      push_sample(65535, 65535, 0);
      push_sample(65535, 0, 12345);
      wait_drained();
      write_reg(CSR_WRAP_LIMIT, 65536);
      write_reg(CSR_TOLERANCE, 2);
      write_reg(CSR_TIMEOUT_MS, 65535);
      write_reg(CSR_SETTLE_COUNT, 2);
      push_sample(65535, 1, 0);
      push_sample(1, 65535, 65534);
      wait_drained();

      // Random phases, rotating through the idle and stall patterns
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         random_setup();
         case (phase % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 78; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 78; end
            default: begin gap_pct = 9; stall_pct = 9; end
         endcase
         stop_at = queued_samples + ITEMS_PER_PHASE;
         while (queued_samples < stop_at) begin
            if ($urandom_range(99) < 15)
               push_sample($urandom, $urandom, $urandom);
            else
               queue_move();
         end
         wait_drained();
      end

      if (fail_count == 0 && predicted_reports.size() == 0) begin
         $display("dual_axis_settle_detector_test: PASS");
      end else begin
         $display("dual_axis_settle_detector_test: FAIL");
      end
      $finish;
   end

   // Run limit
   initial begin
      #(5_000_000);
      $display("dual_axis_settle_detector_test: FAIL");
      $finish;
   end

endmodule

### dual_axis_settle_detector.f
hw/rtl/dasd_pkg.sv
hw/rtl/dasd_wrap_dist.sv
hw/rtl/dual_axis_settle_detector.sv
hw/rtl/dasd_checker.sv
tb/dual_axis_settle_detector_test.sv
